// File: hw/rtl/utf8_decode_validate_unit_macros.svh
// Assertion macros for the UTF-8 decoder and validator.
// Depends on nothing; included by utf8_decode_validate_unit.sv, which carries the assertions.
`ifndef UTF8_DECODE_VALIDATE_UNIT_MACROS_SVH
`define UTF8_DECODE_VALIDATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UDV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UDV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/udv_pkg.sv
// Types and constants shared by the UTF-8 decoder and validator.
// No dependencies.
`default_nettype none

package udv_pkg;

    localparam int CP_W  = 21;
    localparam int CNT_W = 24;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CP_W-1:0] LINE_FEED = 21'h00000A;
    localparam logic [CP_W-1:0] MIN_CP_2  = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP_3  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP_4  = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

    typedef enum logic [2:0] {
        ST_CHAR       = 3'd0,
        ST_END        = 3'd1,
        ST_BAD_LEAD   = 3'd2,
        ST_INCOMPLETE = 3'd3,
        ST_BAD_TRAIL  = 3'd4,
        ST_OVERLONG   = 3'd5,
        ST_INVALID    = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0]       bytes_left;
        logic [2:0]       seq_length;
        logic [CP_W-1:0]  accum_value;
        logic             trail_error;
        logic [CNT_W-1:0] line_count;
        logic [CNT_W-1:0] column_count;
    } dec_state_t;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        status_t          status;
        logic [2:0]       byte_count;
        logic [CNT_W-1:0] line_number;
        logic [CNT_W-1:0] column_number;
    } dec_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/udv_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on udv_pkg for field widths.
`default_nettype none

interface udv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface udv_out_if;
    logic                          valid;
    logic                          ready;
    logic [udv_pkg::CP_W-1:0]      code_point;
    logic [2:0]                    status;
    logic [2:0]                    byte_count;
    logic [udv_pkg::CNT_W-1:0]     line_number;
    logic [udv_pkg::CNT_W-1:0]     column_number;

    modport source (output valid, output code_point, output status, output byte_count,
                    output line_number, output column_number, input ready);
    modport sink   (input valid, input code_point, input status, input byte_count,
                    input line_number, input column_number, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/utf8_decode_validate_unit.sv
// UTF-8 decoder and validator with line and column tracking: top level.
// Depends on udv_pkg, udv_if, udv_step and the assertion macro header.
//
// Usage:
//   in_stream carries one item per byte: data_byte, or stream_end = 1 for the
//   end of the input. out_stream carries one result per finished character,
//   per error and per end mark; bytes inside a multi-byte sequence give none.
//   Results keep input order. Status codes: char, end, bad lead, incomplete,
//   bad trail, overlong, invalid scalar (0 to 6).
//   The last item of a result first sits in the input register; the result
//   register loads from it when it is free or being emptied on out_stream.
//   Throughput: one item per cycle unless out_stream stalls; the decode step
//   between the two registers is a single pass of the state update logic.
//   Stall: while a result waits on out_stream, the buffered item, with or
//   without a result of its own, holds in the input register; one more item
//   is taken only if that register is empty, then in_stream.ready drops.
//   Reset: rst_n clears both registers' valid flags and the sequence state;
//   the line count restarts at 1 and the column count at 0. No clearing pass.
`default_nettype none

`include "utf8_decode_validate_unit_macros.svh"

module utf8_decode_validate_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    udv_in_if.sink     in_stream,
    udv_out_if.source  out_stream
);

    logic                  s1_valid_reg;
    logic [7:0]            s1_byte_reg;
    logic                  s1_end_reg;
    logic                  s1_go;

    udv_pkg::dec_state_t   state_reg;
    udv_pkg::dec_state_t   state_next;
    logic                  emit;
    udv_pkg::dec_result_t  result;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    udv_pkg::dec_result_t  out_reg;

    // the buffered item moves on when the result register is free or emptying
    assign s1_go           = s1_valid_reg && (!out_valid_reg || out_stream.ready);
    assign in_stream.ready = !s1_valid_reg || s1_go;

    udv_step u_step (
        .state      (state_reg),
        .data_byte  (s1_byte_reg),
        .stream_end (s1_end_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_stream.ready)
        begin
            s1_valid_reg <= in_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_stream.valid && in_stream.ready)
        begin
            s1_byte_reg <= in_stream.data_byte;
            s1_end_reg  <= in_stream.stream_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.bytes_left   <= 2'd0;
            state_reg.seq_length   <= 3'd0;
            state_reg.accum_value  <= '0;
            state_reg.trail_error  <= 1'b0;
            state_reg.line_count   <= {{(udv_pkg::CNT_W-1){1'b0}}, 1'b1};
            state_reg.column_count <= '0;
        end
        else if (s1_go)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = emit;
        end
        else if (out_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && emit)
        begin
            out_reg <= result;
        end
    end

    assign out_stream.valid         = out_valid_reg;
    assign out_stream.code_point    = out_reg.code_point;
    assign out_stream.status        = out_reg.status;
    assign out_stream.byte_count    = out_reg.byte_count;
    assign out_stream.line_number   = out_reg.line_number;
    assign out_stream.column_number = out_reg.column_number;

    `UDV_ASSERT_NEXT(a_emit_lands, clk, rst_n, s1_go && emit, out_valid_reg, "result item lost")
    `UDV_ASSERT_IMPL(a_err_zero_cp, clk, rst_n, out_valid_reg && (out_reg.status != udv_pkg::ST_CHAR), out_reg.code_point == '0, "code point set on error")
    `UDV_ASSERT_IMPL(a_end_count, clk, rst_n, out_valid_reg && (out_reg.status == udv_pkg::ST_END), out_reg.byte_count == 3'd0, "byte count on end item")
    `UDV_ASSERT_IMPL(a_seq_len, clk, rst_n, state_reg.bytes_left != 2'd0, state_reg.seq_length > {1'b0, state_reg.bytes_left}, "sequence length below bytes left")
    `UDV_ASSERT_IMPL(a_line_nonzero, clk, rst_n, 1'b1, state_reg.line_count != '0, "line count reached zero")

endmodule

`default_nettype wire

// File: hw/rtl/udv_step.sv
// Decode step: next decoder state and the optional result for one item.
// Depends on udv_pkg.
`default_nettype none

module udv_step (
    input  var udv_pkg::dec_state_t  state,
    input  wire logic [7:0]          data_byte,
    input  wire logic                stream_end,
    output udv_pkg::dec_state_t      state_next,
    output logic                     emit,
    output udv_pkg::dec_result_t     result
);

    logic [udv_pkg::CP_W-1:0] acc_shift;
    logic [1:0]               left_dec;
    logic                     trail_bad;
    logic                     do_count;
    logic [udv_pkg::CP_W-1:0] count_cp;
    logic                     overlong;
    logic                     invalid;
    udv_pkg::status_t         end_status;

    assign acc_shift = {state.accum_value[udv_pkg::CP_W-7:0], data_byte[5:0]};
    assign left_dec  = state.bytes_left - 2'd1;
    assign trail_bad = state.trail_error | (data_byte[7:6] != 2'b10);

    // Checks at the end of a multi-byte sequence, on the completed value
    assign overlong = ((state.seq_length == 3'd2) && (acc_shift < udv_pkg::MIN_CP_2)) ||
                      ((state.seq_length == 3'd3) && (acc_shift < udv_pkg::MIN_CP_3)) ||
                      ((state.seq_length == 3'd4) && (acc_shift < udv_pkg::MIN_CP_4));
    assign invalid  = ((acc_shift >= udv_pkg::SURR_LO) && (acc_shift <= udv_pkg::SURR_HI)) ||
                      (acc_shift > udv_pkg::CP_MAX);

    always_comb
    begin
        if (trail_bad)
        begin
            end_status = udv_pkg::ST_BAD_TRAIL;
        end
        else if (overlong)
        begin
            end_status = udv_pkg::ST_OVERLONG;
        end
        else if (invalid)
        begin
            end_status = udv_pkg::ST_INVALID;
        end
        else
        begin
            end_status = udv_pkg::ST_CHAR;
        end
    end

    always_comb
    begin
        state_next        = state;
        emit              = 1'b0;
        do_count          = 1'b0;
        count_cp          = '0;
        result.code_point = '0;
        result.status     = udv_pkg::ST_CHAR;
        result.byte_count = '0;

        if (stream_end)
        begin
            emit = 1'b1;
            if (state.bytes_left != 2'd0)
            begin
                result.status          = udv_pkg::ST_INCOMPLETE;
                result.byte_count      = state.seq_length - {1'b0, state.bytes_left};
                state_next.bytes_left  = 2'd0;
                state_next.seq_length  = 3'd0;
                state_next.accum_value = '0;
                state_next.trail_error = 1'b0;
            end
            else
            begin
                result.status = udv_pkg::ST_END;
            end
        end
        else if (state.bytes_left == 2'd0)
        begin
            if (data_byte[7] == 1'b0)
            begin
                emit              = 1'b1;
                do_count          = 1'b1;
                count_cp          = {13'd0, data_byte};
                result.code_point = count_cp;
                result.byte_count = 3'd1;
            end
            else if (data_byte[7:5] == 3'b110)
            begin
                state_next.seq_length  = 3'd2;
                state_next.bytes_left  = 2'd1;
                state_next.accum_value = {16'd0, data_byte[4:0]};
                state_next.trail_error = 1'b0;
            end
            else if (data_byte[7:4] == 4'b1110)
            begin
                state_next.seq_length  = 3'd3;
                state_next.bytes_left  = 2'd2;
                state_next.accum_value = {17'd0, data_byte[3:0]};
                state_next.trail_error = 1'b0;
            end
            else if (data_byte[7:3] == 5'b11110)
            begin
                state_next.seq_length  = 3'd4;
                state_next.bytes_left  = 2'd3;
                state_next.accum_value = {18'd0, data_byte[2:0]};
                state_next.trail_error = 1'b0;
            end
            else
            begin
                emit              = 1'b1;
                result.status     = udv_pkg::ST_BAD_LEAD;
                result.byte_count = 3'd1;
            end
        end
        else if (left_dec != 2'd0)
        begin
            // mid-sequence: gather bits, remember a bad trailing byte
            state_next.bytes_left  = left_dec;
            state_next.accum_value = acc_shift;
            state_next.trail_error = trail_bad;
        end
        else
        begin
            emit                   = 1'b1;
            result.status          = end_status;
            result.byte_count      = state.seq_length;
            state_next.bytes_left  = 2'd0;
            state_next.seq_length  = 3'd0;
            state_next.accum_value = '0;
            state_next.trail_error = 1'b0;
            if (end_status == udv_pkg::ST_CHAR)
            begin
                do_count          = 1'b1;
                count_cp          = acc_shift;
                result.code_point = acc_shift;
            end
        end

        if (do_count)
        begin
            if (count_cp == udv_pkg::LINE_FEED)
            begin
                if (state.line_count != udv_pkg::CNT_MAX)
                begin
                    state_next.line_count = state.line_count + 1'b1;
                end
                state_next.column_count = '0;
            end
            else if (state.column_count != udv_pkg::CNT_MAX)
            begin
                state_next.column_count = state.column_count + 1'b1;
            end
        end

        result.line_number   = state_next.line_count;
        result.column_number = state_next.column_count;
    end

endmodule

`default_nettype wire

// File: tb/udv_decode_checker.sv
// Decode checker: watches both channels of the UTF-8 decoder, predicts each result
// and compares it field by field. Depends on udv_pkg and the udv_if interfaces.
module udv_decode_checker
    import udv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    udv_in_if    in_ch,
    udv_out_if   out_ch,
    output int   error_count,
    output int   awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted decoder state
    logic [1:0]       seq_left;
    logic [2:0]       seq_len;
    logic [CP_W-1:0]  cp_acc;
    logic             trail_bad;
    logic [CNT_W-1:0] cur_line;
    logic [CNT_W-1:0] cur_col;

    dec_result_t awaited_results[$];
    int          fails = 0;

    initial begin
        error_count = 0;
        awaiting = 0;
    end

    function automatic void clear_seq();
        seq_left  = '0;
        seq_len   = '0;
        cp_acc    = '0;
        trail_bad = 1'b0;
    endfunction

    function automatic void advance_position(input logic [CP_W-1:0] cp);
        if (cp == LINE_FEED) begin
            if (cur_line != CNT_MAX)
                cur_line = cur_line + 1'b1;
            cur_col = '0;
        end
        else if (cur_col != CNT_MAX)
            cur_col = cur_col + 1'b1;
    endfunction

    function automatic dec_result_t make_result(input logic [CP_W-1:0] cp, input status_t st,
                                                input logic [2:0] n);
        dec_result_t r;
        r.code_point    = cp;
        r.status        = st;
        r.byte_count    = n;
        r.line_number   = cur_line;
        r.column_number = cur_col;
        return r;
    endfunction

    // Returns 1 when the item finishes a character, an error or an end mark.
    function automatic bit decode_item(input logic [7:0] b, input logic fin,
                                       output dec_result_t res);
        logic [CP_W-1:0] v;
        logic [2:0]      n;
        status_t         st;
        res = '0;
        if (fin) begin
            if (seq_left != 0) begin
                res = make_result('0, ST_INCOMPLETE, seq_len - {1'b0, seq_left});
                clear_seq();
            end
            else
                res = make_result('0, ST_END, 3'd0);
            return 1'b1;
        end
        if (seq_left == 0) begin
            if (!b[7]) begin
                advance_position({{(CP_W-8){1'b0}}, b});
                res = make_result({{(CP_W-8){1'b0}}, b}, ST_CHAR, 3'd1);
                return 1'b1;
            end
            if (b[7:5] == 3'b110) begin
                seq_len = 3'd2;
                cp_acc  = {{(CP_W-5){1'b0}}, b[4:0]};
            end
            else if (b[7:4] == 4'b1110) begin
                seq_len = 3'd3;
                cp_acc  = {{(CP_W-4){1'b0}}, b[3:0]};
            end
            else if (b[7:3] == 5'b11110) begin
                seq_len = 3'd4;
                cp_acc  = {{(CP_W-3){1'b0}}, b[2:0]};
            end
            else begin
                res = make_result('0, ST_BAD_LEAD, 3'd1);
                return 1'b1;
            end
            seq_left  = 2'(seq_len - 3'd1);
            trail_bad = 1'b0;
            return 1'b0;
        end
        // a malformed trailing byte still counts towards the sequence
        if (b[7:6] != 2'b10)
            trail_bad = 1'b1;
        cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left != 0)
            return 1'b0;
        v = cp_acc;
        n = seq_len;
        if (trail_bad)
            st = ST_BAD_TRAIL;
        else if ((n == 3'd2 && v < MIN_CP_2) || (n == 3'd3 && v < MIN_CP_3) ||
                 (n == 3'd4 && v < MIN_CP_4))
            st = ST_OVERLONG;
        else if ((v >= SURR_LO && v <= SURR_HI) || v > CP_MAX)
            st = ST_INVALID;
        else
            st = ST_CHAR;
        clear_seq();
        if (st == ST_CHAR)
            advance_position(v);
        else
            v = '0;
        res = make_result(v, st, n);
        return 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        dec_result_t want;
        if (!rst_n) begin
            clear_seq();
            cur_line = 1;
            cur_col  = '0;
            awaited_results.delete();
        end
        else begin
            // results first: a result never belongs to the item taken at the same edge
            if (out_ch.valid && out_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual status %0d cp 0x%0h",
                             $time, out_ch.status, out_ch.code_point);
                    fails++;
                end
                else begin
                    want = awaited_results.pop_front();
                    check_field("code_point", want.code_point, out_ch.code_point);
                    check_field("status", want.status, out_ch.status);
                    check_field("byte_count", want.byte_count, out_ch.byte_count);
                    check_field("line_number", want.line_number, out_ch.line_number);
                    check_field("column_number", want.column_number, out_ch.column_number);
                end
            end
            if (in_ch.valid && in_ch.ready &&
                decode_item(in_ch.data_byte, in_ch.stream_end, want))
                awaited_results.push_back(want);
        end
        error_count <= fails;
        awaiting    <= awaited_results.size();
    end

endmodule

// File: tb/tb.sv
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus and the verdict.
// Depends on udv_pkg, the udv_if interfaces, the decoder RTL and udv_decode_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          END_MARK    = 256;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int          RANDOM_ITEMS = 1950;
    localparam int          DIRECTED[26] = '{
        8'h00, 8'h0A, 8'h41,                // NUL, line feed and a letter
        8'hC2, 8'h80,                       // smallest two-byte character
        8'hC0, 8'h80,                       // overlong two-byte form
        8'hED, 8'hA0, 8'h80,                // surrogate
        8'hF4, 8'h8F, 8'hBF, 8'hBF,         // largest scalar value
        8'hF4, 8'h90, 8'h80, 8'h80,         // just above the largest scalar value
        8'h80, 8'hFF,                       // bad lead bytes
        8'hC3, 8'h41,                       // bad trailing byte
        8'hE2, 8'h82, END_MARK, END_MARK    // end mid-sequence, then plain end
    };
    // code point range that each sequence length encodes without being overlong, capped at the largest scalar
    localparam int unsigned LEN_LO[5] = '{0, 0, 'h80, 'h800, 'h10000};
    localparam int unsigned LEN_HI[5] = '{0, 'h7F, 'h7FF, 'hFFFF, 'h10FFFF};

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned idle_pct = 37;
    int unsigned cycle_cnt = 0;
    int          items_sent = 0;
    int          errors;
    int          awaiting;

    udv_in_if  in_if ();
    udv_out_if out_if ();

    utf8_decode_validate_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if)
    );

    udv_decode_checker decode_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_if),
        .out_ch      (out_if),
        .error_count (errors),
        .awaiting    (awaiting)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_if.ready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // item below 256 is a byte; END_MARK is the end of the stream
    task automatic put_item(input int item);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.stream_end <= (item == END_MARK);
        in_if.data_byte  <= (item == END_MARK) ? 8'($urandom) : 8'(item);
        do
            @(posedge clk);
        while (!in_if.ready);
        items_sent++;
    endtask

    // Encodes cp in len bytes; bad_pos > 0 corrupts that trailing byte,
    // cut > 0 sends only that many bytes and then ends the stream.
    task automatic put_sequence(input logic [20:0] cp, input int len, input int bad_pos,
                                input int cut);
        logic [7:0] seq_bytes [4];
        logic [7:0] junk;
        int         n;
        case (len)
            1: seq_bytes[0] = {1'b0, cp[6:0]};
            2: seq_bytes[0] = {3'b110, cp[10:6]};
            3: seq_bytes[0] = {4'b1110, cp[15:12]};
            default: seq_bytes[0] = {5'b11110, cp[20:18]};
        endcase
        for (int i = 1; i < len; i++)
            seq_bytes[i] = {2'b10, cp[6*(len-1-i) +: 6]};
        if (bad_pos > 0 && bad_pos < len) begin
            junk = 8'($urandom);
            if (junk[7:6] == 2'b10)
                junk[6] = 1'b1;
            seq_bytes[bad_pos] = junk;
        end
        n = (cut > 0) ? cut : len;
        for (int i = 0; i < n; i++)
            put_item(seq_bytes[i]);
        if (cut > 0)
            put_item(END_MARK);
    endtask

    initial
    begin
        int          pick;
        int          len;
        logic [20:0] cp;
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = '0;
        in_if.stream_end = 1'b0;
        out_if.ready     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            put_item(DIRECTED[i]);

        while (items_sent < RANDOM_ITEMS + $size(DIRECTED)) begin
            // one stretch with no idling on either side
            idle_pct = (items_sent >= 700 && items_sent < 1000) ? 0 : 37;
            pick = $urandom_range(99);
            len  = $urandom_range(4, 2);
            cp   = 21'($urandom_range(LEN_HI[len], LEN_LO[len]));
            if (pick < 30)
                put_item(($urandom_range(7) == 0) ? 8'h0A : $urandom_range(127));
            else if (pick < 70)
                put_sequence(cp, len, 0, 0);
            else if (pick < 74)
                put_sequence(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 0, 0);
            else if (pick < 78)
                put_sequence(21'($urandom_range(LEN_LO[len] - 1, 0)), len, 0, 0);
            else if (pick < 80)
                put_sequence(21'($urandom_range(udv_pkg::SURR_HI, udv_pkg::SURR_LO)),
                             3, 0, 0);
            else if (pick < 86)
                put_sequence(cp, len, $urandom_range(len - 1, 1), 0);
            else if (pick < 91)
                put_sequence(cp, len, 0, $urandom_range(len - 1, 1));
            else if (pick < 96)
                put_item($urandom_range(255));
            else
                put_item(END_MARK);
        end
        in_if.valid <= 1'b0;

        // the checker's count is registered and lags behind its queue
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && awaiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
